>>> hw/rtl/ofrt_pkg.sv
package ofrt_pkg;

  localparam int TABLE_ENTRIES   = 16;
  localparam int FRAGS_PER_ENTRY = 16;
  localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int FCNT_W  = $clog2(FRAGS_PER_ENTRY + 1);
  localparam int MEM_DEPTH = TABLE_ENTRIES * FRAGS_PER_ENTRY;
  localparam int FADDR_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int LEN_W   = 17;

  localparam logic [15:0]      DEFAULT_SWEEP = 16'd100;
  localparam logic [LEN_W-1:0] LEN_MAX       = 17'h1ffff;
  localparam logic [31:0]      TIMEOUT_RESET = 32'd1000;
  localparam logic [15:0]      SWEEP_RESET   = 16'd100;

  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_SWEEP   = 1'b1;

  localparam logic OP_ADD     = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [3:0] {
    ST_IN_PROGRESS     = 4'd0,
    ST_COMPLETE        = 4'd1,
    ST_SKIPPED         = 4'd2,
    ST_DUPLICATE       = 4'd3,
    ST_OVERLAP         = 4'd4,
    ST_BOGUS_FINAL     = 4'd5,
    ST_BAD_LENGTH      = 4'd6,
    ST_INVALID         = 4'd7,
    ST_TABLE_FULL      = 4'd8,
    ST_FRAG_STORE_FULL = 4'd9,
    ST_NOT_FOUND       = 4'd10
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_PRE, S_SEARCH, S_RESOLVE, S_FRAG_ADDR, S_FRAG_CHK,
    S_DECIDE, S_COUNT, S_SWEEP, S_RESULT
  } state_e;

  typedef struct packed {
    logic        opcode;
    logic [31:0] packet_key;
    logic [15:0] frag_offset;
    logic [15:0] frag_length;
    logic        is_final;
    logic [31:0] rx_time;
  } in_t;

  typedef struct packed {
    logic [3:0]       status;
    logic [LEN_W-1:0] collected_length;
    logic [LEN_W-1:0] total_length;
  } out_t;

  typedef struct packed {
    logic load;
    logic pre;
    logic search;
    logic resolve;
    logic frag_rd;
    logic frag_chk;
    logic decide;
    logic count;
    logic sweep;
  } cmd_t;

  typedef struct packed {
    logic pre_reject;
    logic is_release;
    logic table_full;
    logic frag_done;
    logic frag_hit;
    logic need_sweep;
    logic idx_last;
  } sts_t;

endpackage

>>> hw/rtl/offset_fragment_reassembly_tracker_unit.sv
// Each beat that passes the pre-checks scans the entry table one entry a cycle; an add
// then walks the entry's fragment list through the fragment memory read port, reading
// and then checking each fragment.
// A periodic expiry sweep then visits every entry; a new beat is taken in the cycle after the result.
// The result strobe lasts one cycle; the receiver cannot stall it.
// Reset clears all entry valid bits, the add counter and restores the configuration registers.
module offset_fragment_reassembly_tracker_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_idx_i,
  input  logic [31:0]    cfg_data_i,
  input  logic           start_i,
  output logic           busy_o,
  input  ofrt_pkg::in_t  in_i,
  output logic           res_valid_o,
  output ofrt_pkg::out_t res_o
);
  import ofrt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ofrt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy_o      (busy_o),
    .res_valid_o (res_valid_o)
  );

  ofrt_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .res_o      (res_o)
  );

endmodule

>>> hw/rtl/ofrt_ctrl.sv
module ofrt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  ofrt_pkg::sts_t sts_i,
  output ofrt_pkg::cmd_t cmd_o,
  output logic          busy_o,
  output logic          res_valid_o
);
  import ofrt_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    busy_o      = (state_q != S_IDLE);
    res_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_PRE;
        end
      end
      S_PRE: begin
        cmd_o.pre = 1'b1;
        state_d   = sts_i.pre_reject ? S_RESULT : S_SEARCH;
      end
      S_SEARCH: begin
        cmd_o.search = 1'b1;
        if (sts_i.idx_last) state_d = S_RESOLVE;
      end
      S_RESOLVE: begin
        cmd_o.resolve = 1'b1;
        if (sts_i.is_release) state_d = S_RESULT;
        else if (sts_i.table_full) state_d = S_COUNT;
        else state_d = S_FRAG_ADDR;
      end
      S_FRAG_ADDR: begin
        if (sts_i.frag_done) begin
          state_d = S_DECIDE;
        end else begin
          cmd_o.frag_rd = 1'b1;
          state_d       = S_FRAG_CHK;
        end
      end
      S_FRAG_CHK: begin
        cmd_o.frag_chk = 1'b1;
        state_d        = sts_i.frag_hit ? S_COUNT : S_FRAG_ADDR;
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = S_COUNT;
      end
      S_COUNT: begin
        cmd_o.count = 1'b1;
        state_d     = sts_i.need_sweep ? S_SWEEP : S_RESULT;
      end
      S_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.idx_last) state_d = S_RESULT;
      end
      S_RESULT: begin
        res_valid_o = 1'b1;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

>>> hw/rtl/ofrt_datapath.sv
module ofrt_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_idx_i,
  input  logic [31:0]    cfg_data_i,
  input  ofrt_pkg::in_t  in_i,
  input  ofrt_pkg::cmd_t cmd_i,
  output ofrt_pkg::sts_t sts_o,
  output ofrt_pkg::out_t res_o
);
  import ofrt_pkg::*;

  logic [31:0] timeout_q;
  logic [15:0] sweep_q;
  logic [15:0] cnt_q;

  logic                   valid_q [TABLE_ENTRIES];
  logic [31:0]            key_q   [TABLE_ENTRIES];
  logic [31:0]            first_q [TABLE_ENTRIES];
  logic [31:0]            tmo_q   [TABLE_ENTRIES];
  logic [LEN_W-1:0]       tot_q   [TABLE_ENTRIES];
  logic [LEN_W-1:0]       col_q   [TABLE_ENTRIES];
  logic [FCNT_W-1:0]      fcnt_q  [TABLE_ENTRIES];

  logic [15:0]      fs_mem [MEM_DEPTH];
  logic [LEN_W-1:0] fe_mem [MEM_DEPTH];
  logic [15:0]      fs_rd_q;
  logic [LEN_W-1:0] fe_rd_q;

  in_t               item_q;
  logic [IDX_W-1:0]  idx_q, e_q, free_q;
  logic              found_q, freev_q;
  logic [FCNT_W-1:0] k_q;
  out_t              res_q;

  logic [IDX_W-1:0]   sel, ra;
  logic [LEN_W-1:0]   fend;
  logic [FCNT_W-1:0]  n;
  logic [FADDR_W-1:0] faddr;
  logic               exp_ra, dup, ovl;
  logic [15:0]        lim;
  logic [LEN_W:0]     col_sum;
  logic [LEN_W-1:0]   new_col, new_tot;
  status_e            new_st;

  function automatic logic expired(input logic [31:0] now, input logic [31:0] first,
                                   input logic [31:0] to);
    logic [32:0] lim_t;
    lim_t = {1'b0, first} + {1'b0, to};
    return (to != 32'd0) && ({1'b0, now} > lim_t);
  endfunction

  assign sel    = found_q ? e_q : free_q;
  assign ra     = (cmd_i.search || cmd_i.sweep) ? idx_q : (cmd_i.resolve ? sel : e_q);
  assign exp_ra = expired(item_q.rx_time, first_q[ra], tmo_q[ra]);
  assign fend   = LEN_W'({1'b0, item_q.frag_offset} + {1'b0, item_q.frag_length} - 17'd1);
  assign n      = fcnt_q[e_q];
  assign faddr  = FADDR_W'(FADDR_W'(e_q) * FADDR_W'(FRAGS_PER_ENTRY)) + FADDR_W'(k_q);
  assign dup    = (LEN_W'(fs_rd_q) == LEN_W'(item_q.frag_offset)) && (fe_rd_q == fend);
  assign ovl    = ((fs_rd_q <= item_q.frag_offset) &&
                   (LEN_W'(item_q.frag_offset) <= fe_rd_q)) ||
                  ((item_q.frag_offset <= fs_rd_q) && (LEN_W'(fs_rd_q) <= fend));
  assign lim    = (sweep_q == 16'd0) ? DEFAULT_SWEEP : sweep_q;
  assign col_sum = {1'b0, col_q[e_q]} + {2'b0, item_q.frag_length};
  assign new_col = col_sum[LEN_W] ? LEN_MAX : col_sum[LEN_W-1:0];
  assign new_tot = item_q.is_final ?
                   LEN_W'({1'b0, item_q.frag_offset} + {1'b0, item_q.frag_length}) :
                   tot_q[e_q];
  assign new_st  = (new_tot == '0 || new_col < new_tot) ? ST_IN_PROGRESS :
                   ((new_col == new_tot) ? ST_COMPLETE : ST_BAD_LENGTH);

  assign sts_o.pre_reject = (item_q.opcode == OP_ADD) &&
                            ((item_q.frag_length == 16'd0) ||
                             (item_q.is_final && item_q.frag_offset == 16'd0) ||
                             (timeout_q == 32'd0));
  assign sts_o.is_release = (item_q.opcode == OP_RELEASE);
  assign sts_o.table_full = !found_q && !freev_q;
  assign sts_o.frag_done  = (k_q >= n);
  assign sts_o.frag_hit   = dup || ovl;
  assign sts_o.need_sweep = (cnt_q >= lim);
  assign sts_o.idx_last   = (idx_q == IDX_W'(TABLE_ENTRIES - 1));
  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
      sweep_q   <= SWEEP_RESET;
      cnt_q     <= '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) valid_q[i] <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_TIMEOUT: timeout_q <= cfg_data_i;
          CFG_SWEEP:   sweep_q   <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (cmd_i.resolve) begin
        if (sts_o.is_release) begin
          if (found_q && col_q[e_q] != '0) valid_q[e_q] <= 1'b0;
        end else if (!sts_o.table_full) begin
          valid_q[sel] <= 1'b1;
        end
      end
      if (cmd_i.count) begin
        cnt_q <= sts_o.need_sweep ? 16'd0 : cnt_q + 16'd1;
      end
      if (cmd_i.sweep && valid_q[idx_q] && exp_ra) valid_q[idx_q] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= in_i;
    if (cmd_i.pre) begin
      idx_q   <= '0;
      found_q <= 1'b0;
      freev_q <= 1'b0;
      res_q   <= '{status: (item_q.frag_length != 16'd0 && item_q.is_final &&
                            item_q.frag_offset == 16'd0) ? ST_SKIPPED : ST_INVALID,
                   collected_length: '0, total_length: '0};
    end
    if (cmd_i.search) begin
      idx_q <= idx_q + IDX_W'(1);
      if (valid_q[idx_q] && key_q[idx_q] == item_q.packet_key && !found_q) begin
        found_q <= 1'b1;
        e_q     <= idx_q;
      end
      if (!valid_q[idx_q] && !freev_q) begin
        freev_q <= 1'b1;
        free_q  <= idx_q;
      end
    end
    if (cmd_i.resolve) begin
      k_q <= '0;
      e_q <= sel;
      if (sts_o.is_release) begin
        if (found_q) begin
          res_q <= '{status: ST_COMPLETE, collected_length: col_q[e_q],
                     total_length: tot_q[e_q]};
        end else begin
          res_q <= '{status: ST_NOT_FOUND, collected_length: '0, total_length: '0};
        end
      end else if (sts_o.table_full) begin
        res_q <= '{status: ST_TABLE_FULL, collected_length: '0, total_length: '0};
      end else begin
        res_q <= '0;
        if (!found_q || exp_ra) begin
          key_q[sel]   <= item_q.packet_key;
          first_q[sel] <= item_q.rx_time;
          tmo_q[sel]   <= timeout_q;
          tot_q[sel]   <= '0;
          col_q[sel]   <= '0;
          fcnt_q[sel]  <= '0;
        end
      end
    end
    if (cmd_i.frag_rd) begin
      fs_rd_q <= fs_mem[faddr];
      fe_rd_q <= fe_mem[faddr];
    end
    if (cmd_i.frag_chk) begin
      k_q   <= k_q + FCNT_W'(1);
      res_q <= '{status: dup ? ST_DUPLICATE : ST_OVERLAP, collected_length: col_q[e_q],
                 total_length: tot_q[e_q]};
    end
    if (cmd_i.decide) begin
      if (item_q.is_final && tot_q[e_q] != '0) begin
        res_q <= '{status: ST_BOGUS_FINAL, collected_length: col_q[e_q],
                   total_length: tot_q[e_q]};
      end else if (n >= FCNT_W'(FRAGS_PER_ENTRY)) begin
        res_q <= '{status: ST_FRAG_STORE_FULL, collected_length: col_q[e_q],
                   total_length: tot_q[e_q]};
      end else begin
        fs_mem[faddr] <= item_q.frag_offset;
        fe_mem[faddr] <= fend;
        fcnt_q[e_q]   <= n + FCNT_W'(1);
        col_q[e_q]    <= new_col;
        tot_q[e_q]    <= new_tot;
        res_q <= '{status: new_st, collected_length: new_col, total_length: new_tot};
      end
    end
    if (cmd_i.count && sts_o.need_sweep) idx_q <= '0;
    if (cmd_i.sweep) idx_q <= idx_q + IDX_W'(1);
  end

endmodule

>>> hw/rtl/ofrt_checker.sv
module ofrt_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input logic           busy_o,
  input logic           res_valid_o,
  input ofrt_pkg::out_t res_o
);
  import ofrt_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted beat did not raise busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> busy_o)
    else $error("result strobe while idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> (!busy_o && !res_valid_o))
    else $error("block not idle after result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.status <= 4'd10))
    else $error("status code out of range");

endmodule

bind offset_fragment_reassembly_tracker_unit ofrt_checker u_ofrt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);
